// ===== design/pncs_pkg.sv =====
package pncs_pkg;

   localparam int IDX_W  = 21;
   localparam int CNT_W  = 32;
   localparam int SUM_W  = 42;
   localparam int SQ_W   = 52;
   localparam int SPR_W  = 64;
   localparam int STAT_W = 2;
   localparam int DET_W  = 10;
   localparam int ROW_W  = 4;
   localparam int ROB_W  = 3;
   localparam int MCM_W  = 4;
   localparam int ADC_W  = 5;
   localparam int SMP_W  = 10;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SAT   = 2'd2;

   localparam logic CMD_ACCUM = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam int CHAMBERS_PER_SECTOR = 30;
   localparam int CHAMBERS_PER_STACK  = 6;
   localparam int ADC_LAST            = 20;
   localparam int ADCS_PER_MCM        = 21;
   localparam int SHORT_STACK         = 2;

   // det / 30 as multiply by reciprocal, exact for det < 1024
   localparam int DIV30_MUL   = 1093;
   localparam int DIV30_SHIFT = 15;
   // r / 6 as multiply by reciprocal, exact for r < 30
   localparam int DIV6_MUL    = 11;
   localparam int DIV6_SHIFT  = 6;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  square;
   } stat_type;

   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [IDX_W-1:0] addr;
      stat_type         wr_data;
   } store_req_type;

   typedef struct packed {
      logic [DET_W-1:0] detector;
      logic [ROW_W-1:0] pad_row;
      logic [ROB_W-1:0] readout_board;
      logic [MCM_W-1:0] mcm_number;
      logic [ADC_W-1:0] adc_channel;
   } geom_type;

   function automatic logic [5:0] sector_of(input logic [DET_W-1:0] det);
      logic [20:0] prod;
      prod = 21'(det) * 21'(DIV30_MUL);
      return prod[DIV30_SHIFT +: 6];
   endfunction

   function automatic logic [2:0] stack_of(input logic [4:0] rem);
      logic [8:0] prod;
      prod = 9'(rem) * 9'(DIV6_MUL);
      return prod[DIV6_SHIFT +: 3];
   endfunction

endpackage

// ===== design/pncs_if.sv =====
interface pncs_req_if;
   import pncs_pkg::*;

   logic             valid;
   logic             ready;
   logic             command;
   logic [DET_W-1:0] detector;
   logic [ROW_W-1:0] pad_row;
   logic [ROB_W-1:0] readout_board;
   logic [MCM_W-1:0] mcm_number;
   logic [ADC_W-1:0] adc_channel;
   logic [SMP_W-1:0] adc_sample;

   modport source (output valid, command, detector, pad_row, readout_board, mcm_number,
                   adc_channel, adc_sample, input ready);
   modport sink (input valid, command, detector, pad_row, readout_board, mcm_number,
                 adc_channel, adc_sample, output ready);
endinterface

interface pncs_rsp_if;
   import pncs_pkg::*;

   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  channel_index;
   logic [CNT_W-1:0]  sample_count;
   logic [SUM_W-1:0]  sample_sum;
   logic [SQ_W-1:0]   square_sum;
   logic [SPR_W-1:0]  spread_numerator;
   logic [STAT_W-1:0] status;

   modport source (output valid, channel_index, sample_count, sample_sum, square_sum,
                   spread_numerator, status, input ready);
   modport sink (input valid, channel_index, sample_count, sample_sum, square_sum,
                 spread_numerator, status, output ready);
endinterface

// ===== design/pncs_index.sv =====
module pncs_index #(
   parameter int SECTORS          = 18,
   parameter int LAYERS           = 6,
   parameter int STACKS           = 5,
   parameter int ROWS_LONG        = 16,
   parameter int ROWS_SHORT       = 12,
   parameter int CHANNELS_PER_ROW = 168
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  pncs_pkg::geom_type         in_geom,
   output logic                       out_valid,
   output logic [pncs_pkg::IDX_W-1:0] out_index,
   output logic                       out_ok
);
   import pncs_pkg::*;

   localparam int CHAMBER_LONG  = ROWS_LONG * CHANNELS_PER_ROW;
   localparam int CHAMBER_SHORT = ROWS_SHORT * CHANNELS_PER_ROW;
   localparam int LAYER_SIZE    = (STACKS - 1) * CHAMBER_LONG + CHAMBER_SHORT;
   localparam int SECTOR_SIZE   = LAYERS * LAYER_SIZE;
   localparam int STAGES        = 4;

   logic [STAGES-1:0] valid_ff, valid_in;

   // stage 1: sector, remainder mod 30, row channel
   logic [5:0]       sector;
   logic [DET_W-1:0] rem_wide;
   logic [2:0]       col;
   logic [7:0]       rowch;
   logic [5:0]       s1_sector_ff;
   logic [4:0]       s1_rem_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [7:0]       s1_rowch_ff;
   logic             s1_adc_ok_ff;

   // stage 2: stack, layer, range checks
   logic [2:0]       stack;
   logic [2:0]       layer;
   logic             short_chamber;
   logic             row_ok;
   logic             in_range;
   logic [5:0]       s2_sector_ff;
   logic [2:0]       s2_stack_ff;
   logic [2:0]       s2_layer_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic [7:0]       s2_rowch_ff;
   logic             s2_ok_ff;

   // stage 3: partial sums
   logic [IDX_W-1:0] offset;
   logic [IDX_W-1:0] s3_a_ff;
   logic [IDX_W-1:0] s3_b_ff;
   logic             s3_ok_ff;

   // stage 4
   logic [IDX_W-1:0] s4_index_ff;
   logic             s4_ok_ff;

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      sector   = sector_of(in_geom.detector);
      rem_wide = in_geom.detector - (DET_W'(sector) * DET_W'(CHAMBERS_PER_SECTOR));
      col      = {in_geom.readout_board[0], in_geom.mcm_number[1:0]};
      rowch    = 8'(col) * 8'(ADCS_PER_MCM) + 8'(ADC_LAST) - 8'(in_geom.adc_channel);
   end

   always_comb begin
      stack         = stack_of(s1_rem_ff);
      layer         = 3'(s1_rem_ff - 5'(stack) * 5'(CHAMBERS_PER_STACK));
      short_chamber = (stack == 3'(SHORT_STACK));
      row_ok        = short_chamber ? (5'(s1_row_ff) < 5'(ROWS_SHORT))
                                    : (5'(s1_row_ff) < 5'(ROWS_LONG));
      in_range      = (s1_sector_ff < 6'(SECTORS)) && (layer < 3'(LAYERS)) &&
                      (stack < 3'(STACKS)) && s1_adc_ok_ff && row_ok &&
                      (9'(s1_rowch_ff) < 9'(CHANNELS_PER_ROW));
   end

   always_comb begin
      if (s2_stack_ff <= 3'(SHORT_STACK)) begin
         offset = IDX_W'(s2_stack_ff) * IDX_W'(CHAMBER_LONG);
      end else begin
         offset = IDX_W'(s2_stack_ff - 3'd1) * IDX_W'(CHAMBER_LONG) + IDX_W'(CHAMBER_SHORT);
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= sector;
      s1_rem_ff    <= rem_wide[4:0];
      s1_row_ff    <= in_geom.pad_row;
      s1_rowch_ff  <= rowch;
      s1_adc_ok_ff <= (in_geom.adc_channel <= ADC_W'(ADC_LAST));

      s2_sector_ff <= s1_sector_ff;
      s2_stack_ff  <= stack;
      s2_layer_ff  <= layer;
      s2_row_ff    <= s1_row_ff;
      s2_rowch_ff  <= s1_rowch_ff;
      s2_ok_ff     <= in_range;

      s3_a_ff  <= IDX_W'(s2_sector_ff) * IDX_W'(SECTOR_SIZE) +
                  IDX_W'(s2_layer_ff) * IDX_W'(LAYER_SIZE);
      s3_b_ff  <= offset + IDX_W'(s2_row_ff) * IDX_W'(CHANNELS_PER_ROW) + IDX_W'(s2_rowch_ff);
      s3_ok_ff <= s2_ok_ff;

      s4_index_ff <= s3_a_ff + s3_b_ff;
      s4_ok_ff    <= s3_ok_ff;
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_index = s4_index_ff;
   assign out_ok    = s4_ok_ff;

endmodule

// ===== design/pncs_store.sv =====
module pncs_store #(
   parameter int DEPTH = 1378944
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pncs_pkg::store_req_type req,
   output pncs_pkg::stat_type      rd_data,
   output logic                    clearing
);
   import pncs_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   stat_type mem [DEPTH];

   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic              clearing_ff, clearing_in;
   stat_type          rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   stat_type          wr_data;

   always_comb begin
      clear_addr_in = clear_addr_ff;
      clearing_in   = clearing_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         clearing_ff   <= 1'b1;
      end else begin
         clear_addr_ff <= clear_addr_in;
         clearing_ff   <= clearing_in;
      end
   end

   assign wr_en   = clearing_ff || req.wr_en;
   assign wr_addr = clearing_ff ? clear_addr_ff : req.addr[ADDR_W-1:0];
   assign wr_data = clearing_ff ? '0 : req.wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr[ADDR_W-1:0]];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

// ===== design/pncs_spread.sv =====
module pncs_spread (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  pncs_pkg::stat_type         operand,
   output logic                       done,
   output logic [pncs_pkg::SPR_W-1:0] result
);
   import pncs_pkg::*;

   // n*q - s*s over five partial products on one 32x26 multiplier
   localparam int PART_W = SQ_W / 2;
   localparam int HALF_W = SUM_W / 2;
   localparam int MUL_A_W = CNT_W;
   localparam int PROD_W = CNT_W + PART_W;
   localparam int ACC_W  = CNT_W + SQ_W + 1;

   localparam logic [2:0] STEP_NQ_LO  = 3'd0;
   localparam logic [2:0] STEP_NQ_HI  = 3'd1;
   localparam logic [2:0] STEP_SS_LO  = 3'd2;
   localparam logic [2:0] STEP_SS_MID = 3'd3;
   localparam logic [2:0] STEP_SS_HI  = 3'd4;

   stat_type           op_ff;
   logic               busy_ff, busy_in;
   logic [2:0]         step_ff, step_in;
   logic               prod_valid_ff, prod_valid_in;
   logic [2:0]         prod_step_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               done_ff, done_in;
   logic [MUL_A_W-1:0] mul_a;
   logic [PART_W-1:0]  mul_b;
   logic [ACC_W-1:0]   prod_ext;

   always_comb begin
      unique case (step_ff)
         STEP_NQ_LO: begin
            mul_a = op_ff.count;
            mul_b = op_ff.square[PART_W-1:0];
         end
         STEP_NQ_HI: begin
            mul_a = op_ff.count;
            mul_b = op_ff.square[SQ_W-1:PART_W];
         end
         STEP_SS_LO: begin
            mul_a = MUL_A_W'(op_ff.sum[HALF_W-1:0]);
            mul_b = PART_W'(op_ff.sum[HALF_W-1:0]);
         end
         STEP_SS_MID: begin
            mul_a = MUL_A_W'(op_ff.sum[SUM_W-1:HALF_W]);
            mul_b = PART_W'(op_ff.sum[HALF_W-1:0]);
         end
         STEP_SS_HI: begin
            mul_a = MUL_A_W'(op_ff.sum[SUM_W-1:HALF_W]);
            mul_b = PART_W'(op_ff.sum[SUM_W-1:HALF_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      acc_in   = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         unique case (prod_step_ff)
            STEP_NQ_LO:  acc_in = acc_ff + prod_ext;
            STEP_NQ_HI:  acc_in = acc_ff + (prod_ext << PART_W);
            STEP_SS_LO:  acc_in = acc_ff - prod_ext;
            STEP_SS_MID: acc_in = acc_ff - (prod_ext << (HALF_W + 1));
            STEP_SS_HI:  acc_in = acc_ff - (prod_ext << (2 * HALF_W));
            default:     acc_in = acc_ff;
         endcase
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      prod_valid_in = busy_ff;
      done_in       = done_ff;
      if (start) begin
         busy_in       = 1'b1;
         step_in       = STEP_NQ_LO;
         prod_valid_in = 1'b0;
         done_in       = 1'b0;
      end else begin
         if (busy_ff) begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_SS_HI) begin
               busy_in = 1'b0;
            end
         end
         if (prod_valid_ff && prod_step_ff == STEP_SS_HI) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= STEP_NQ_LO;
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         step_ff       <= step_in;
         prod_valid_ff <= prod_valid_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= operand;
      end
      prod_ff      <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_step_ff <= step_ff;
      acc_ff       <= acc_in;
   end

   // negative or beyond 64 bits saturates
   assign result = (|acc_ff[ACC_W-1:SPR_W]) ? '1 : acc_ff[SPR_W-1:0];
   assign done   = done_ff;

endmodule

// ===== design/per_channel_noise_statistics.sv =====
// Per-channel noise statistics: each request names a readout channel by geometry and carries
// one ADC sample; the channel's count, sum and sum of squares are kept in one on-chip RAM,
// updated (or only read), and returned with the exact spread numerator n*sumsq - sum^2,
// saturated at 64 bits. After reset the RAM, DEPTH entries (1,378,944 at the default geometry),
// is cleared one entry per cycle with req_chan.ready low. One request is worked on at a time;
// its steps are the geometry-to-index pipeline, one RAM read, one read-modify-write, the spread
// on a shared 32x26 multiplier, a step to see the spread finish, and the load into the response
// register. An out-of-range request skips the RAM and the spread. The next request is taken in
// the cycle after the response is registered; a response that has not been taken holds the
// following request in its final step.
module per_channel_noise_statistics #(
   parameter int SECTORS          = 18,
   parameter int LAYERS           = 6,
   parameter int STACKS           = 5,
   parameter int ROWS_LONG        = 16,
   parameter int ROWS_SHORT       = 12,
   parameter int CHANNELS_PER_ROW = 168
) (
   input logic        clock,
   input logic        reset,
   pncs_req_if.sink   req_chan,
   pncs_rsp_if.source rsp_chan
);
   import pncs_pkg::*;

   localparam int DEPTH = SECTORS * LAYERS *
                          ((STACKS - 1) * ROWS_LONG + ROWS_SHORT) * CHANNELS_PER_ROW;
   localparam int SQR_W = 2 * SMP_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MAP    = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_SPREAD = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              cmd_ff;
   logic [SMP_W-1:0]  sample_ff;
   logic [SQR_W-1:0]  sample_sq_ff;
   logic [IDX_W-1:0]  index_ff;
   stat_type          stat_ff;
   logic [STAT_W-1:0] status_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff;
   stat_type          rsp_stat_ff;
   logic [SPR_W-1:0]  rsp_spread_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   logic              accept;
   geom_type          geom;
   logic              idx_valid;
   logic [IDX_W-1:0]  idx_out;
   logic              idx_ok;
   store_req_type     store_req;
   stat_type          rd_data;
   logic              clearing;
   logic              accumulate;
   logic              full;
   stat_type          added;
   stat_type          next_stat;
   logic              spread_start;
   logic              spread_done;
   logic [SPR_W-1:0]  spread_result;
   logic              out_load;
   logic              out_range;

   assign req_chan.ready = (state_ff == S_IDLE) && !clearing;
   assign accept         = req_chan.valid && req_chan.ready;

   assign geom = '{detector:      req_chan.detector,
                   pad_row:       req_chan.pad_row,
                   readout_board: req_chan.readout_board,
                   mcm_number:    req_chan.mcm_number,
                   adc_channel:   req_chan.adc_channel};

   pncs_index #(
      .SECTORS          (SECTORS),
      .LAYERS           (LAYERS),
      .STACKS           (STACKS),
      .ROWS_LONG        (ROWS_LONG),
      .ROWS_SHORT       (ROWS_SHORT),
      .CHANNELS_PER_ROW (CHANNELS_PER_ROW)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_geom   (geom),
      .out_valid (idx_valid),
      .out_index (idx_out),
      .out_ok    (idx_ok)
   );

   pncs_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .req      (store_req),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   pncs_spread u_spread (
      .clock   (clock),
      .reset   (reset),
      .start   (spread_start),
      .operand (next_stat),
      .done    (spread_done),
      .result  (spread_result)
   );

   always_comb begin
      accumulate   = (cmd_ff == CMD_ACCUM);
      full         = (rd_data.count == '1);
      added.count  = rd_data.count + CNT_W'(1);
      added.sum    = rd_data.sum + SUM_W'(sample_ff);
      added.square = rd_data.square + SQ_W'(sample_sq_ff);
      next_stat    = (accumulate && !full) ? added : rd_data;
   end

   always_comb begin
      store_req.rd_en   = (state_ff == S_MAP) && idx_valid && idx_ok;
      store_req.wr_en   = (state_ff == S_UPDATE) && accumulate && !full;
      store_req.addr    = (state_ff == S_MAP) ? idx_out : index_ff;
      store_req.wr_data = added;
   end

   assign spread_start = (state_ff == S_UPDATE);
   assign out_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign out_range    = (status_ff == STATUS_RANGE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_MAP;
         end
         S_MAP: begin
            if (idx_valid) state_in = idx_ok ? S_UPDATE : S_DONE;
         end
         S_UPDATE: begin
            state_in = S_SPREAD;
         end
         S_SPREAD: begin
            if (spread_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_chan.command;
         sample_ff    <= req_chan.adc_sample;
         sample_sq_ff <= SQR_W'(req_chan.adc_sample) * SQR_W'(req_chan.adc_sample);
      end
      if (state_ff == S_MAP && idx_valid) begin
         index_ff  <= idx_out;
         status_ff <= idx_ok ? STATUS_OK : STATUS_RANGE;
      end
      if (state_ff == S_UPDATE) begin
         stat_ff   <= next_stat;
         status_ff <= (accumulate && full) ? STATUS_SAT : STATUS_OK;
      end
      if (out_load) begin
         rsp_index_ff  <= out_range ? '0 : index_ff;
         rsp_stat_ff   <= out_range ? '0 : stat_ff;
         rsp_spread_ff <= out_range ? '0 : spread_result;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.channel_index    = rsp_index_ff;
   assign rsp_chan.sample_count     = rsp_stat_ff.count;
   assign rsp_chan.sample_sum       = rsp_stat_ff.sum;
   assign rsp_chan.square_sum       = rsp_stat_ff.square;
   assign rsp_chan.spread_numerator = rsp_spread_ff;
   assign rsp_chan.status           = rsp_status_ff;

endmodule

// ===== design/pncs_checker.sv =====
module pncs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pncs_pkg::IDX_W-1:0]  rsp_channel_index,
   input logic [pncs_pkg::CNT_W-1:0]  rsp_sample_count,
   input logic [pncs_pkg::SUM_W-1:0]  rsp_sample_sum,
   input logic [pncs_pkg::SQ_W-1:0]   rsp_square_sum,
   input logic [pncs_pkg::SPR_W-1:0]  rsp_spread_numerator,
   input logic [pncs_pkg::STAT_W-1:0] rsp_status
);
   import pncs_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && req_ready;

   // RAM clear runs right after reset
   a_no_request_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request port ready right after reset");

   a_response_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_spread_numerator))
      else $error("stalled response dropped or changed");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RANGE |->
         rsp_channel_index == '0 && rsp_sample_count == '0 && rsp_sample_sum == '0 &&
         rsp_square_sum == '0 && rsp_spread_numerator == '0)
      else $error("out-of-range response carries data");

   a_sat_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_SAT |-> rsp_sample_count == '1)
      else $error("saturation flagged below full count");

   a_empty_channel: assert property (@(posedge clock) disable iff (reset || req_seen)
      rsp_valid && rsp_status != STATUS_RANGE && rsp_sample_count == '0 |->
         rsp_sample_sum == '0 && rsp_square_sum == '0 && rsp_spread_numerator == '0)
      else $error("empty channel has nonzero totals");

endmodule

bind per_channel_noise_statistics pncs_checker u_pncs_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_channel_index    (rsp_chan.channel_index),
   .rsp_sample_count     (rsp_chan.sample_count),
   .rsp_sample_sum       (rsp_chan.sample_sum),
   .rsp_square_sum       (rsp_chan.square_sum),
   .rsp_spread_numerator (rsp_chan.spread_numerator),
   .rsp_status           (rsp_chan.status)
);

// ===== tb/per_channel_noise_statistics_test.sv =====
`timescale 1ns / 1ps

module per_channel_noise_statistics_test;
   import pncs_pkg::*;

   localparam int SECTORS          = 18;
   localparam int LAYERS           = 6;
   localparam int STACKS           = 5;
   localparam int ROWS_LONG        = 16;
   localparam int ROWS_SHORT       = 12;
   localparam int CHANNELS_PER_ROW = 168;
   localparam int CHAMBER_LONG     = ROWS_LONG * CHANNELS_PER_ROW;
   localparam int CHAMBER_SHORT    = ROWS_SHORT * CHANNELS_PER_ROW;
   localparam int LAYER_SIZE       = (STACKS - 1) * CHAMBER_LONG + CHAMBER_SHORT;
   localparam int SECTOR_SIZE      = LAYERS * LAYER_SIZE;
   localparam int DEPTH            = SECTORS * SECTOR_SIZE;

   localparam int RANDOM_REQUESTS  = 1850;
   localparam int POOL_SIZE        = 12;
   localparam int DRAIN_AT         = 1100;
   localparam int PHASE_ONE        = 620;
   localparam int PHASE_TWO        = 1240;
   localparam int HOLD_AT          = 1400;
   localparam int HOLD_LEN         = 300;
   localparam int TAIL_CYCLES      = 40;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic             command;
      logic [DET_W-1:0] detector;
      logic [ROW_W-1:0] pad_row;
      logic [ROB_W-1:0] readout_board;
      logic [MCM_W-1:0] mcm_number;
      logic [ADC_W-1:0] adc_channel;
      logic [SMP_W-1:0] adc_sample;
      logic             hold_for_drain;
   } sample_request;

   typedef struct packed {
      logic [IDX_W-1:0]  channel_index;
      logic [CNT_W-1:0]  sample_count;
      logic [SUM_W-1:0]  sample_sum;
      logic [SQ_W-1:0]   square_sum;
      logic [SPR_W-1:0]  spread_numerator;
      logic [STAT_W-1:0] status;
   } stat_result;

   logic clock;
   logic reset;

   pncs_req_if req_chan ();
   pncs_rsp_if rsp_chan ();

   per_channel_noise_statistics i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sample_request request_queue[$];
   stat_result    awaited_stats[$];
   sample_request offered;
   stat_result    observed;
   stat_result    oldest;

   logic [CNT_W-1:0] channel_count  [int unsigned];
   logic [SUM_W-1:0] channel_sum    [int unsigned];
   logic [SQ_W-1:0]  channel_square [int unsigned];

   int unsigned accepted_count = 0;
   int unsigned result_count   = 0;
   int unsigned accum_count    = 0;
   int unsigned read_count     = 0;
   int unsigned range_count    = 0;
   int unsigned mismatches     = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic bit roll(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic void add_request(input sample_request r);
      request_queue = {request_queue, r};
   endfunction

   function automatic sample_request make_request(input logic cmd, input int det,
                                                  input int row, input int rob, input int mcm,
                                                  input int ch, input int smp);
      sample_request r;
      r                = '0;
      r.command        = cmd;
      r.detector       = DET_W'(det);
      r.pad_row        = ROW_W'(row);
      r.readout_board  = ROB_W'(rob);
      r.mcm_number     = MCM_W'(mcm);
      r.adc_channel    = ADC_W'(ch);
      r.adc_sample     = SMP_W'(smp);
      return r;
   endfunction

   function automatic sample_request valid_geometry();
      int det;
      int stack;
      det   = $urandom_range(0, SECTORS * CHAMBERS_PER_SECTOR - 1);
      stack = (det % CHAMBERS_PER_SECTOR) / CHAMBERS_PER_STACK;
      return make_request(CMD_ACCUM, det,
                          $urandom_range(0, (stack == SHORT_STACK) ? ROWS_SHORT - 1
                                                                   : ROWS_LONG - 1),
                          $urandom_range(0, 7), $urandom_range(0, 15),
                          $urandom_range(0, ADC_LAST), $urandom_range(0, 1023));
   endfunction

   function automatic stat_result predict_noise_stats(input sample_request r);
      stat_result   res;
      int unsigned  sector;
      int unsigned  layer;
      int unsigned  stack;
      int unsigned  rows;
      int unsigned  col;
      int unsigned  rowch;
      int unsigned  offset;
      int unsigned  idx;
      logic [127:0] wide;
      res    = '0;
      sector = r.detector / CHAMBERS_PER_SECTOR;
      layer  = r.detector % CHAMBERS_PER_STACK;
      stack  = (r.detector % CHAMBERS_PER_SECTOR) / CHAMBERS_PER_STACK;
      rows   = (stack == SHORT_STACK) ? ROWS_SHORT : ROWS_LONG;
      if (sector >= SECTORS || layer >= LAYERS || stack >= STACKS ||
          r.adc_channel > ADC_LAST || r.pad_row >= rows) begin
         res.status = STATUS_RANGE;
         return res;
      end
      col   = (r.mcm_number % 4) + (r.readout_board[0] ? 4 : 0);
      rowch = col * ADCS_PER_MCM + ADC_LAST - r.adc_channel;
      if (rowch >= CHANNELS_PER_ROW) begin
         res.status = STATUS_RANGE;
         return res;
      end
      offset = (stack < 3) ? stack * CHAMBER_LONG
                           : (stack - 1) * CHAMBER_LONG + CHAMBER_SHORT;
      idx = sector * SECTOR_SIZE + layer * LAYER_SIZE + offset
            + r.pad_row * CHANNELS_PER_ROW + rowch;
      if (idx >= DEPTH) begin
         res.status = STATUS_RANGE;
         return res;
      end
      if (!channel_count.exists(idx)) begin
         channel_count[idx]  = '0;
         channel_sum[idx]    = '0;
         channel_square[idx] = '0;
      end
      res.status = STATUS_OK;
      if (r.command == CMD_ACCUM) begin
         if (channel_count[idx] == '1) begin
            res.status = STATUS_SAT;
         end else begin
            channel_count[idx]  = channel_count[idx] + CNT_W'(1);
            channel_sum[idx]    = channel_sum[idx] + SUM_W'(r.adc_sample);
            channel_square[idx] = channel_square[idx] + SQ_W'(r.adc_sample)
                                  * SQ_W'(r.adc_sample);
         end
      end
      res.channel_index = IDX_W'(idx);
      res.sample_count  = channel_count[idx];
      res.sample_sum    = channel_sum[idx];
      res.square_sum    = channel_square[idx];
      wide = 128'(channel_count[idx]) * 128'(channel_square[idx])
             - 128'(channel_sum[idx]) * 128'(channel_sum[idx]);
      res.spread_numerator = (wide[127:64] != '0) ? '1 : wide[63:0];
      return res;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] seen);
      if (want !== seen) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("result %0d %s: expected %0h actual %0h", result_count, field,
                     want, seen);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_stats = {awaited_stats, predict_noise_stats(offered)};
            accepted_count++;
            if (awaited_stats[$].status == STATUS_RANGE) range_count++;
            else if (offered.command == CMD_READ) read_count++;
            else accum_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (request_queue.size() > 0 &&
                !(request_queue[0].hold_for_drain && awaited_stats.size() != 0) &&
                !roll((accepted_count < PHASE_ONE) ? 35 :
                      (accepted_count < PHASE_TWO) ? 84 : 0)) begin
               offered                 = request_queue.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.command       <= offered.command;
               req_chan.detector      <= offered.detector;
               req_chan.pad_row       <= offered.pad_row;
               req_chan.readout_board <= offered.readout_board;
               req_chan.mcm_number    <= offered.mcm_number;
               req_chan.adc_channel   <= offered.adc_channel;
               req_chan.adc_sample    <= offered.adc_sample;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            observed.channel_index    = rsp_chan.channel_index;
            observed.sample_count     = rsp_chan.sample_count;
            observed.sample_sum       = rsp_chan.sample_sum;
            observed.square_sum       = rsp_chan.square_sum;
            observed.spread_numerator = rsp_chan.spread_numerator;
            observed.status           = rsp_chan.status;
            if (awaited_stats.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result %0d unexpected: index %0h status %0d", result_count,
                           observed.channel_index, observed.status);
            end else begin
               oldest = awaited_stats.pop_front();
               check_field("channel_index", 64'(oldest.channel_index),
                           64'(observed.channel_index));
               check_field("sample_count", 64'(oldest.sample_count),
                           64'(observed.sample_count));
               check_field("sample_sum", 64'(oldest.sample_sum), 64'(observed.sample_sum));
               check_field("square_sum", 64'(oldest.square_sum), 64'(observed.square_sum));
               check_field("spread_numerator", oldest.spread_numerator,
                           observed.spread_numerator);
               check_field("status", 64'(oldest.status), 64'(observed.status));
            end
            result_count++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (result_count == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !roll((result_count < PHASE_ONE) ? 84 :
                                    (result_count < PHASE_TWO) ? 35 : 0);
         end
      end
   end

   initial begin
      sample_request pool[POOL_SIZE];
      sample_request r;
      int unsigned   pick;

      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.command       = CMD_ACCUM;
      req_chan.detector      = '0;
      req_chan.pad_row       = '0;
      req_chan.readout_board = '0;
      req_chan.mcm_number    = '0;
      req_chan.adc_channel   = '0;
      req_chan.adc_sample    = '0;
      rsp_chan.ready         = 1'b0;

      // directed: fresh read, repeated channel, mcm alias, extremes, range errors
      add_request(make_request(CMD_READ,  0, 0, 0, 0, 0, 1023));
      add_request(make_request(CMD_ACCUM, 0, 0, 0, 0, 0, 1023));
      add_request(make_request(CMD_ACCUM, 0, 0, 0, 0, 0, 0));
      add_request(make_request(CMD_ACCUM, 0, 0, 0, 4, 0, 512));
      add_request(make_request(CMD_READ,  0, 0, 0, 8, 0, 77));
      add_request(make_request(CMD_ACCUM, 539, 15, 7, 15, 0, 1023));
      add_request(make_request(CMD_ACCUM, 539, 15, 7, 15, 0, 1023));
      add_request(make_request(CMD_READ,  539, 15, 7, 15, 0, 0));
      add_request(make_request(CMD_ACCUM, 0, 0, 0, 0, 20, 1));
      add_request(make_request(CMD_ACCUM, 540, 0, 0, 0, 0, 5));
      add_request(make_request(CMD_ACCUM, 1023, 15, 7, 15, 31, 1023));
      add_request(make_request(CMD_READ,  600, 3, 2, 1, 4, 9));
      add_request(make_request(CMD_ACCUM, 12, 11, 1, 3, 10, 300));
      add_request(make_request(CMD_ACCUM, 12, 12, 0, 0, 0, 1));
      add_request(make_request(CMD_ACCUM, 17, 15, 0, 0, 0, 1));
      add_request(make_request(CMD_ACCUM, 0, 0, 0, 0, 21, 9));
      add_request(make_request(CMD_READ,  0, 0, 0, 0, 31, 9));
      add_request(make_request(CMD_ACCUM, 18, 15, 2, 1, 5, 700));
      add_request(make_request(CMD_ACCUM, 29, 3, 5, 2, 7, 1000));
      add_request(make_request(CMD_ACCUM, 6, 7, 4, 3, 14, 3));
      add_request(make_request(CMD_READ,  18, 15, 2, 1, 5, 0));

      for (int i = 0; i < POOL_SIZE; i++) pool[i] = valid_geometry();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            r = pool[$urandom_range(0, POOL_SIZE - 1)];
            r.adc_sample = SMP_W'($urandom_range(0, 1023));
            if (roll(12)) r.adc_sample = roll(50) ? '1 : '0;
         end else if (pick < 88) begin
            r = valid_geometry();
         end else begin
            r = make_request(CMD_ACCUM, $urandom_range(0, 1023), $urandom_range(0, 15),
                             $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 31), $urandom_range(0, 1023));
         end
         r.command        = roll(20) ? CMD_READ : CMD_ACCUM;
         r.hold_for_drain = (i == DRAIN_AT);
         add_request(r);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_chan.valid) @(posedge clock);
      while (awaited_stats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests: %0d accumulates, %0d reads, %0d out of range", accepted_count,
               accum_count, read_count, range_count);
      $display("%0d responses checked across %0d channels, %0d mismatches", result_count,
               channel_count.num(), mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // store clear after reset covers all DEPTH entries before requests are taken
   initial begin
      #80ms;
      $display("simulation failed");
      $finish;
   end

endmodule
